### sv/fxpow_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed-point integer power block.
// Holds the sequencer state, writeback tags and the fixed port widths. No dependencies.
package fxpow_pkg;

   localparam int FRAC_BITS_W = 5;
   localparam int BASE_W      = 32;
   localparam int EXP_W       = 31;
   localparam int RESULT_W    = 32;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // which working register a product returns to
   typedef enum logic {
      TGT_VAL,
      TGT_RES
   } tgt_type;

   typedef struct packed {
      logic    valid;
      tgt_type tgt;
      logic    ovf;
   } wb_type;

endpackage

### sv/fxpow_mul_unit.sv
`timescale 1ns / 1ps
// Shared multiply and round unit: one registered WORD_BITS x WORD_BITS product,
// then half-up rounding and a right shift by the working scale. Uses fxpow_pkg.
module fxpow_mul_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           issue_valid,
   input  fxpow_pkg::tgt_type             issue_tgt,
   input  logic [WORD_BITS-1:0]           op_a,
   input  logic [WORD_BITS-1:0]           op_b,
   input  logic [$clog2(WORD_BITS)-1:0]   sc,
   input  logic [WORD_BITS-1:0]           half,
   output fxpow_pkg::wb_type              wb_ctl,
   output logic [WORD_BITS-1:0]           wb_value
);
   import fxpow_pkg::*;

   logic [2*WORD_BITS-1:0] prod_ff, prod_in;
   logic                   pv_ff, pv_in;
   tgt_type                tgt_ff, tgt_in;
   logic [2*WORD_BITS-1:0] rounded;
   logic [2*WORD_BITS-1:0] shifted;

   always_comb begin
      prod_in = op_a * op_b;
      pv_in   = issue_valid;
      tgt_in  = issue_tgt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
      prod_ff <= prod_in;
      tgt_ff  <= tgt_in;
   end

   // product plus half an LSB cannot carry out of 2*WORD_BITS
   always_comb begin
      rounded      = prod_ff + {{WORD_BITS{1'b0}}, half};
      shifted      = rounded >> sc;
      wb_value     = shifted[WORD_BITS-1:0];
      wb_ctl.valid = pv_ff;
      wb_ctl.tgt   = tgt_ff;
      wb_ctl.ovf   = pv_ff & (|shifted[2*WORD_BITS-1:WORD_BITS]);
   end

endmodule

### sv/fixed_point_integer_power.sv
`timescale 1ns / 1ps
// Top level of the fixed-point integer power block: sequencer, working registers,
// config register and output register. Uses fxpow_pkg and fxpow_mul_unit.
//
//  port group  dir  contents (low bit first)
//  req_*       in   tdata: base[31:0], exponent[62:32], zero pad
//  rsp_*       out  tdata: result[31:0], overflow[32], zero pad
//  csr_*       in   wr_data: fraction_bits[4:0], written when wr_en
//
// One item runs setup, then for each exponent bit up to its highest set bit (at least one
// bit) a square phase and a multiply phase, then a flush and the output load. The square
// chain through the one multiplier and its round stage paces the loop.
// req_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next item is accepted. Reset is synchronous and
// restores fraction_bits to 16.
module fixed_point_integer_power #(
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fxpow_pkg::REQ_TDATA_W-1:0]    req_tdata,   // base, exponent
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fxpow_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // result, overflow
   input  logic                                 csr_wr_en,
   input  logic [fxpow_pkg::FRAC_BITS_W-1:0]    csr_wr_data  // fraction_bits
);
   import fxpow_pkg::*;

   localparam int SC_BITS = $clog2(WORD_BITS);
   localparam logic [SC_BITS-1:0]     SC_MAX   = SC_BITS'(WORD_BITS - 2);
   localparam logic [FRAC_BITS_W-1:0] FRAC_MAX = FRAC_BITS_W'(WORD_BITS - 2);

   state_type               state_ff, state_in;
   logic                    phase_ff, phase_in;
   logic [WORD_BITS-1:0]    r_ff, r_in;
   logic [WORD_BITS-1:0]    val_ff, val_in;
   logic [EXP_W-1:0]        ex_ff, ex_in;
   logic [SC_BITS-1:0]      sc_ff, sc_in;
   logic [WORD_BITS-1:0]    half_ff, half_in;
   logic                    guard_ff, guard_in;
   logic                    ovf_ff, ovf_in;
   logic [FRAC_BITS_W-1:0]  frac_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [RESULT_W-1:0]     out_result_ff, out_result_in;
   logic                    out_ovf_ff, out_ovf_in;

   logic                    issue_valid;
   tgt_type                 issue_tgt;
   logic [WORD_BITS-1:0]    op_a;
   wb_type                  wb_ctl;
   logic [WORD_BITS-1:0]    wb_value;

   logic                    req_fire, rsp_fire, more;
   logic [WORD_BITS-1:0]    base_w;
   logic [SC_BITS-1:0]      sc_base;
   logic                    guard_new;
   logic [SC_BITS-1:0]      sc_new;
   logic [WORD_BITS-1:0]    one_new;

   fxpow_mul_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_mul (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_tgt   (issue_tgt),
      .op_a        (op_a),
      .op_b        (val_ff),
      .sc          (sc_ff),
      .half        (half_ff),
      .wb_ctl      (wb_ctl),
      .wb_value    (wb_value)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = out_valid_ff & rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RESULT_W - 1){1'b0}}, out_ovf_ff, out_result_ff};
   assign more       = |ex_ff[EXP_W-1:1];

   // setup of the working scale, guard bit and 1.0 for a new item
   always_comb begin
      base_w    = req_tdata[WORD_BITS-1:0];
      sc_base   = (frac_ff > FRAC_MAX) ? SC_MAX : frac_ff[SC_BITS-1:0];
      guard_new = ~base_w[WORD_BITS-1] & (sc_base != '0);
      sc_new    = sc_base + SC_BITS'(guard_new);
      one_new   = WORD_BITS'(1) << sc_new;
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      r_in          = r_ff;
      val_in        = val_ff;
      ex_in         = ex_ff;
      sc_in         = sc_ff;
      half_in       = half_ff;
      guard_in      = guard_ff;
      ovf_in        = ovf_ff;
      out_valid_in  = rsp_fire ? 1'b0 : out_valid_ff;
      out_result_in = out_result_ff;
      out_ovf_in    = out_ovf_ff;
      issue_valid   = 1'b0;
      issue_tgt     = TGT_VAL;
      op_a          = val_ff;

      // returning product lands in its working register
      if (wb_ctl.valid) begin
         if (wb_ctl.tgt == TGT_RES) begin
            r_in = wb_value;
         end else begin
            val_in = wb_value;
         end
         ovf_in = ovf_ff | wb_ctl.ovf;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               val_in   = guard_new ? {base_w[WORD_BITS-2:0], 1'b0} : base_w;
               ex_in    = req_tdata[BASE_W +: EXP_W];
               sc_in    = sc_new;
               guard_in = guard_new;
               r_in     = one_new;
               half_in  = one_new >> 1;
               ovf_in   = 1'b0;
               phase_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!phase_ff) begin
               // square for the next bit; skipped after the highest set bit
               issue_valid = more;
               issue_tgt   = TGT_VAL;
               phase_in    = 1'b1;
            end else begin
               // val_ff still holds this bit's power while the square returns
               issue_valid = ex_ff[0];
               issue_tgt   = TGT_RES;
               op_a        = r_ff;
               ex_in       = ex_ff >> 1;
               phase_in    = 1'b0;
               if (!more) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_result_in = RESULT_W'(r_ff >> guard_ff);
               out_ovf_in    = ovf_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         frac_ff      <= FRAC_BITS_W'(16);
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            frac_ff <= csr_wr_data;
         end
      end
      r_ff          <= r_in;
      val_ff        <= val_in;
      ex_ff         <= ex_in;
      sc_ff         <= sc_in;
      half_ff       <= half_in;
      guard_ff      <= guard_in;
      ovf_ff        <= ovf_in;
      out_result_ff <= out_result_in;
      out_ovf_ff    <= out_ovf_in;
   end

endmodule
